### rtl/core/geo_prb_pkg.sv
// Shared types and constants of the geo point radius box filter.
package geo_prb_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_REGS   = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ASPECT_MULT = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X_LOW   = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X_HIGH  = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_LOW   = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_HIGH  = 8'd7;

	localparam logic [31:0] ALL_ONES_32  = 32'hFFFF_FFFF;
	localparam logic [63:0] ALL_ONES_64  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] S32_MIN      = 32'h8000_0000;
	localparam logic [31:0] S32_MAX      = 32'h7FFF_FFFF;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} point_t;

	typedef struct packed {
		logic        inside_res;
		logic [63:0] sq_distance;
	} result_t;

	// Query values seen by the point datapath.
	typedef struct packed {
		logic               busy;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic        [31:0] aspect_mult;
		logic signed [31:0] eff_x_low;
		logic signed [31:0] eff_x_high;
		logic signed [31:0] eff_y_low;
		logic signed [31:0] eff_y_high;
		logic        [63:0] sq_radius_limit;
	} query_t;

	typedef enum logic [1:0] {
		DRV_IDLE,
		DRV_START,
		DRV_DIV,
		DRV_CLIP
	} derive_state_t;

endpackage

### rtl/core/geo_prb_div.sv
// Radix-2 restoring divider: floor(({num_hi, all ones}) / den) for num_hi < den.
module geo_prb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num_hi,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quot
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quot_q;
	logic [33:0] trial;
	logic        ge;
	logic [31:0] rem_next;

	// Shift in a one from the low dividend word each step.
	always_comb begin
		trial    = {1'b0, rem_q, 1'b1} - {2'b00, den};
		ge       = ~trial[33];
		rem_next = ge ? trial[31:0] : {rem_q[30:0], 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num_hi;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			quot_q <= {quot_q[30:0], ge};
		end
	end

	assign done = busy_q && (cnt_q == 5'd0);
	assign quot = quot_q;

endmodule

### rtl/core/geo_prb_cfg.sv
// Query registers and the sequencer that derives the effective box and radius limit.
module geo_prb_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [geo_prb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [geo_prb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output geo_prb_pkg::query_t                 query
);

	logic [31:0] center_x_q, center_y_q, radius_q, aspect_q;
	logic [31:0] box_xl_q, box_xh_q, box_yl_q, box_yh_q;
	logic [31:0] eff_xl_q, eff_xh_q, eff_yl_q, eff_yh_q;
	logic [63:0] sq_lim_q;
	logic [31:0] maxdx_q;
	logic        use_quot_q;

	geo_prb_pkg::derive_state_t state_q, state_nxt;

	logic        wr_hit;
	logic        radius_all;
	logic        need_div;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quot;
	logic [31:0] maxdx;
	logic signed [33:0] hx, lx, hy, ly;
	logic signed [33:0] bxl, bxh, byl, byh;

	assign wr_hit     = cfg_we && (cfg_index < geo_prb_pkg::CFG_IDX_W'(geo_prb_pkg::CFG_REGS));
	assign radius_all = (radius_q == geo_prb_pkg::ALL_ONES_32);
	assign need_div   = !radius_all && (aspect_q != 32'd0) && (radius_q < aspect_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= geo_prb_pkg::ALL_ONES_32;
			aspect_q   <= '0;
			box_xl_q   <= geo_prb_pkg::S32_MIN;
			box_xh_q   <= geo_prb_pkg::S32_MAX;
			box_yl_q   <= geo_prb_pkg::S32_MIN;
			box_yh_q   <= geo_prb_pkg::S32_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				geo_prb_pkg::REG_CENTER_X:    center_x_q <= cfg_wdata;
				geo_prb_pkg::REG_CENTER_Y:    center_y_q <= cfg_wdata;
				geo_prb_pkg::REG_RADIUS:      radius_q   <= cfg_wdata;
				geo_prb_pkg::REG_ASPECT_MULT: aspect_q   <= cfg_wdata;
				geo_prb_pkg::REG_BOX_X_LOW:   box_xl_q   <= cfg_wdata;
				geo_prb_pkg::REG_BOX_X_HIGH:  box_xh_q   <= cfg_wdata;
				geo_prb_pkg::REG_BOX_Y_LOW:   box_yl_q   <= cfg_wdata;
				geo_prb_pkg::REG_BOX_Y_HIGH:  box_yh_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Next state: a write to a query register index restarts the derivation from any state.
	always_comb begin
		state_nxt = state_q;
		if (wr_hit) begin
			state_nxt = geo_prb_pkg::DRV_START;
		end else begin
			case (state_q)
				geo_prb_pkg::DRV_IDLE:  state_nxt = geo_prb_pkg::DRV_IDLE;
				geo_prb_pkg::DRV_START: state_nxt = need_div ? geo_prb_pkg::DRV_DIV
				                                              : geo_prb_pkg::DRV_CLIP;
				geo_prb_pkg::DRV_DIV:   state_nxt = div_done ? geo_prb_pkg::DRV_CLIP
				                                              : geo_prb_pkg::DRV_DIV;
				geo_prb_pkg::DRV_CLIP:  state_nxt = geo_prb_pkg::DRV_IDLE;
				default:                state_nxt = geo_prb_pkg::DRV_IDLE;
			endcase
		end
	end

	always_comb begin
		div_start = (state_q == geo_prb_pkg::DRV_START) && need_div;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= geo_prb_pkg::DRV_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	geo_prb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (radius_q),
		.den    (aspect_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Half-width in x when no divide is needed: radius, or saturated when r >= aspect.
	always_ff @(posedge clk) begin
		if (state_q == geo_prb_pkg::DRV_START) begin
			maxdx_q    <= (aspect_q == 32'd0) ? radius_q : geo_prb_pkg::ALL_ONES_32;
			use_quot_q <= need_div;
		end
	end

	always_comb begin
		maxdx = use_quot_q ? div_quot : maxdx_q;
		hx  = {{2{center_x_q[31]}}, center_x_q} + {2'b00, maxdx};
		lx  = {{2{center_x_q[31]}}, center_x_q} - {2'b00, maxdx};
		hy  = {{2{center_y_q[31]}}, center_y_q} + {2'b00, radius_q};
		ly  = {{2{center_y_q[31]}}, center_y_q} - {2'b00, radius_q};
		bxl = {{2{box_xl_q[31]}}, box_xl_q};
		bxh = {{2{box_xh_q[31]}}, box_xh_q};
		byl = {{2{box_yl_q[31]}}, box_yl_q};
		byh = {{2{box_yh_q[31]}}, box_yh_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_xl_q <= geo_prb_pkg::S32_MIN;
			eff_xh_q <= geo_prb_pkg::S32_MAX;
			eff_yl_q <= geo_prb_pkg::S32_MIN;
			eff_yh_q <= geo_prb_pkg::S32_MAX;
			sq_lim_q <= geo_prb_pkg::ALL_ONES_64;
		end else if (state_q == geo_prb_pkg::DRV_CLIP) begin
			if (radius_all) begin
				eff_xl_q <= box_xl_q;
				eff_xh_q <= box_xh_q;
				eff_yl_q <= box_yl_q;
				eff_yh_q <= box_yh_q;
				sq_lim_q <= geo_prb_pkg::ALL_ONES_64;
			end else begin
				// Clipped bounds always land inside the signed 32-bit range.
				eff_xl_q <= (lx > bxl) ? lx[31:0] : box_xl_q;
				eff_xh_q <= (hx < bxh) ? hx[31:0] : box_xh_q;
				eff_yl_q <= (ly > byl) ? ly[31:0] : box_yl_q;
				eff_yh_q <= (hy < byh) ? hy[31:0] : box_yh_q;
				sq_lim_q <= 64'(radius_q) * 64'(radius_q);
			end
		end
	end

	always_comb begin
		query.busy            = (state_q != geo_prb_pkg::DRV_IDLE);
		query.center_x        = center_x_q;
		query.center_y        = center_y_q;
		query.aspect_mult     = aspect_q;
		query.eff_x_low       = eff_xl_q;
		query.eff_x_high      = eff_xh_q;
		query.eff_y_low       = eff_yl_q;
		query.eff_y_high      = eff_yh_q;
		query.sq_radius_limit = sq_lim_q;
	end

endmodule

### rtl/core/geo_prb_pipe.sv
// Four-stage point datapath: differences and box test, x scaling and y square, x square, sum and limit test.
module geo_prb_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  geo_prb_pkg::point_t  pt,
	input  geo_prb_pkg::query_t  query,
	output logic                 ready,
	output logic                 out_valid,
	input  logic                 out_stall,
	output geo_prb_pkg::result_t out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic [31:0] dx_s1, dy_s1;
	logic        box_s1, box_s2, box_s3;
	logic [31:0] dxm_s2;
	logic [63:0] dysq_s2, dysq_s3, dxsq_s3;
	geo_prb_pkg::result_t res_s4;

	logic signed [32:0] diff_x, diff_y;
	logic [32:0] abs_x, abs_y;
	logic        box_hit;
	logic [63:0] scale_prod;
	logic [63:0] sum;

	// A stage advances when it is empty or its successor advances.
	assign en4   = !v_s4 || !out_stall;
	assign en3   = !v_s3 || en4;
	assign en2   = !v_s2 || en3;
	assign en1   = !v_s1 || en2;
	assign ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= take;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		diff_x  = {pt.point_x[31], pt.point_x} - {query.center_x[31], query.center_x};
		diff_y  = {pt.point_y[31], pt.point_y} - {query.center_y[31], query.center_y};
		abs_x   = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
		abs_y   = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
		box_hit = (pt.point_x >= query.eff_x_low) && (pt.point_x <= query.eff_x_high) &&
		          (pt.point_y >= query.eff_y_low) && (pt.point_y <= query.eff_y_high);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1  <= abs_x[31:0];
			dy_s1  <= abs_y[31:0];
			box_s1 <= box_hit;
		end
	end

	assign scale_prod = 64'(dx_s1) * 64'(query.aspect_mult);

	always_ff @(posedge clk) begin
		if (en2) begin
			dxm_s2  <= (query.aspect_mult != 32'd0) ? scale_prod[63:32] : dx_s1;
			dysq_s2 <= 64'(dy_s1) * 64'(dy_s1);
			box_s2  <= box_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			dxsq_s3 <= 64'(dxm_s2) * 64'(dxm_s2);
			dysq_s3 <= dysq_s2;
			box_s3  <= box_s2;
		end
	end

	// Wrap the sum at 64 bits.
	assign sum = dxsq_s3 + dysq_s3;

	always_ff @(posedge clk) begin
		if (en4) begin
			res_s4.sq_distance <= sum;
			res_s4.inside_res  <= box_s3 && (sum <= query.sq_radius_limit);
		end
	end

	assign out_valid = v_s4;
	assign out_data  = res_s4;

endmodule

### rtl/core/geo_point_radius_box_filter_core.sv
// Top level of the geo point radius box filter.
//
// Points enter on the point channel (point_valid, point_stall, point) and one
// result per point leaves on the result channel (result_valid, result_stall,
// result), in order. A transaction completes at a rising edge where valid is
// high and stall is low.
// A point passes the four-stage datapath (difference and box test, x
// scaling and y square, x square, sum and radius test) in that order.
// Throughput: one point per cycle while point_stall stays low (it rises on
// result back-pressure, a configuration write or a rederivation).
// Configuration: write cfg_index/cfg_wdata with cfg_we while no point is in
// flight. Each write to a register index 0..7 rederives the effective box and
// squared radius; the point channel stalls meanwhile, in states START and
// CLIP and, if the x half-width needs the 32-step divide (aspect set, radius
// below it, not unlimited), DIV between them. Other indexes are ignored.
// Reset clears all stage valid bits and loads the query reset values (center
// 0, unlimited radius, no aspect, full box); the block accepts points at once.
// When the receiver stalls, the last stage holds its result, the stages behind
// it fill up, and the pipe stalls points only when stage one cannot advance.
module geo_point_radius_box_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  geo_prb_pkg::point_t                 point,
	output logic                                result_valid,
	input  logic                                result_stall,
	output geo_prb_pkg::result_t                result,
	input  logic                                cfg_we,
	input  logic [geo_prb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [geo_prb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	geo_prb_pkg::query_t query;
	logic                pipe_ready;
	logic                take;

	// Hold points off while stage one cannot advance or the query is being written or rederived.
	assign point_stall = !pipe_ready || query.busy || cfg_we;
	assign take        = point_valid && !point_stall;

	geo_prb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.query     (query)
	);

	geo_prb_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.pt        (point),
		.query     (query),
		.ready     (pipe_ready),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (result)
	);

endmodule

### verif/tb_top.sv
// Testbench for the geo point radius box filter: directed table, then random traffic under three idle patterns.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import geo_prb_pkg::*;

	// Timing and run length
	localparam int unsigned CYCLE_LIMIT      = 400_000;
	localparam int unsigned QUIET_CYCLES     = 40;   // covers a rederivation with the divide, plus the datapath
	localparam int unsigned RANDOM_PER_PHASE = 510;
	localparam int unsigned MAX_REPORTS      = 10;

	// Idle percentages per phase: sender then receiver
	localparam int unsigned SEND_IDLE [3] = '{25, 57, 0};
	localparam int unsigned RECV_IDLE [3] = '{57, 25, 0};

	// Indexes past the register file; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(CFG_REGS);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

	typedef enum logic [1:0] {
		CMD_POINT,
		CMD_CFG,
		CMD_PACE
	} cmd_kind_t;

	// One entry of the stimulus stream: a point, a register write or an idle-pattern change
	typedef struct packed {
		cmd_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [6:0]            send_pct;
		logic [6:0]            recv_pct;
		point_t                pt;
		logic                  has_exp;
		result_t               exp_res;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_stall;
	point_t point = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	geo_point_radius_box_filter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Query model: registers as written, plus the derived box and limit
	// ------------------------------------------------------------------
	logic signed [31:0] q_center_x, q_center_y;
	logic        [31:0] q_radius, q_aspect;
	logic signed [31:0] q_box_x_low, q_box_x_high, q_box_y_low, q_box_y_high;
	longint             eff_x_low, eff_x_high, eff_y_low, eff_y_high;
	logic        [63:0] sq_radius_lim;

	// Narrow the user box by the radius (x half-width widened by the aspect)
	function automatic void rederive_query();
		logic [63:0] quot, half_w;
		longint cx, cy, rad;
		cx = longint'(q_center_x);
		cy = longint'(q_center_y);
		rad = longint'({32'd0, q_radius});
		eff_x_low = longint'(q_box_x_low);
		eff_x_high = longint'(q_box_x_high);
		eff_y_low = longint'(q_box_y_low);
		eff_y_high = longint'(q_box_y_high);
		if (q_radius == ALL_ONES_32) begin
			// unlimited radius: the user box stands as written
			sq_radius_lim = ALL_ONES_64;
			return;
		end
		sq_radius_lim = {32'd0, q_radius} * {32'd0, q_radius};
		half_w = {32'd0, q_radius};
		if (q_aspect != '0) begin
			// divide {radius, all ones} by the aspect, then saturate to 32 bits
			quot = {q_radius, ALL_ONES_32} / {32'd0, q_aspect};
			half_w = (quot >= {32'd0, ALL_ONES_32}) ? {32'd0, ALL_ONES_32} : quot;
		end
		if (cx + longint'(half_w) < eff_x_high) eff_x_high = cx + longint'(half_w);
		if (cx - longint'(half_w) > eff_x_low) eff_x_low = cx - longint'(half_w);
		if (cy + rad < eff_y_high) eff_y_high = cy + rad;
		if (cy - rad > eff_y_low) eff_y_low = cy - rad;
	endfunction

	function automatic void reset_query();
		q_center_x = '0;
		q_center_y = '0;
		q_radius = ALL_ONES_32;
		q_aspect = '0;
		q_box_x_low = S32_MIN;
		q_box_x_high = S32_MAX;
		q_box_y_low = S32_MIN;
		q_box_y_high = S32_MAX;
		rederive_query();
	endfunction

	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
		REG_CENTER_X:    q_center_x = data;
		REG_CENTER_Y:    q_center_y = data;
		REG_RADIUS:      q_radius = data;
		REG_ASPECT_MULT: q_aspect = data;
		REG_BOX_X_LOW:   q_box_x_low = data;
		REG_BOX_X_HIGH:  q_box_x_high = data;
		REG_BOX_Y_LOW:   q_box_y_low = data;
		REG_BOX_Y_HIGH:  q_box_y_high = data;
		default:         return;   // drop writes past the register file
		endcase
		rederive_query();
	endfunction

	// Squared distance (x scaled by the aspect) and the inside flag for one point
	function automatic result_t filter_point(input point_t p);
		longint px, py, dxs, dys;
		logic [63:0] ux, uy, sq;
		result_t r;
		px = longint'($signed(p.point_x));
		py = longint'($signed(p.point_y));
		dxs = px - longint'(q_center_x);
		dys = py - longint'(q_center_y);
		ux = (dxs < 0) ? -dxs : dxs;
		uy = (dys < 0) ? -dys : dys;
		if (q_aspect != '0)
			ux = (ux * {32'd0, q_aspect}) >> 32;
		sq = ux * ux + uy * uy;   // wraps at 64 bits
		r.sq_distance = sq;
		r.inside_res = (px >= eff_x_low) && (px <= eff_x_high) &&
			(py >= eff_y_low) && (py <= eff_y_high) && (sq <= sq_radius_lim);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------
	cmd_t stim_q [$];
	logic [31:0] plan_cx = '0, plan_cy = '0, plan_r = ALL_ONES_32;   // query as planned

	function automatic cmd_t point_row(input int x, input int y);
		cmd_t c;
		c = '0;
		c.kind = CMD_POINT;
		c.pt.point_x = x;
		c.pt.point_y = y;
		return c;
	endfunction

	function automatic cmd_t check_row(input int x, input int y, input logic exp_in,
			input logic [63:0] sq);
		cmd_t c;
		c = point_row(x, y);
		c.has_exp = 1'b1;
		c.exp_res.inside_res = exp_in;
		c.exp_res.sq_distance = sq;
		return c;
	endfunction

	function automatic cmd_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cmd_t c;
		c = '0;
		c.kind = CMD_CFG;
		c.idx = idx;
		c.data = data;
		return c;
	endfunction

	function automatic cmd_t pace_row(input int unsigned send, input int unsigned recv);
		cmd_t c;
		c = '0;
		c.kind = CMD_PACE;
		c.send_pct = 7'(send);
		c.recv_pct = 7'(recv);
		return c;
	endfunction

	// Queue a command and follow the planned center and radius so points can aim near them
	function automatic void queue_cmd(input cmd_t c);
		stim_q.push_back(c);
		if (c.kind == CMD_CFG) begin
			case (c.idx)
			REG_CENTER_X: plan_cx = c.data;
			REG_CENTER_Y: plan_cy = c.data;
			REG_RADIUS:   plan_r = c.data;
			default:      ;
			endcase
		end
	endfunction

	function automatic logic [31:0] near_offset(input logic [31:0] span);
		logic [31:0] mag;
		mag = $urandom_range(span, 0);
		return ($urandom_range(1, 0) != 0) ? mag : -mag;
	endfunction

	function automatic logic [31:0] extreme_value();
		case ($urandom_range(3, 0))
		0:       return S32_MIN;
		1:       return S32_MAX;
		2:       return ALL_ONES_32;
		default: return '0;
		endcase
	endfunction

	function automatic logic [31:0] pick_cfg_value(input logic [CFG_IDX_W-1:0] idx);
		logic [31:0] v;
		int unsigned sel;
		sel = $urandom_range(9, 0);
		v = $urandom();
		case (idx)
		REG_CENTER_X, REG_CENTER_Y: begin
			if (sel < 2) v = extreme_value();
			else if (sel < 6) v = near_offset(32'd3000);
		end
		REG_RADIUS: begin
			if (sel == 0) v = ALL_ONES_32;
			else if (sel == 1) v = ALL_ONES_32 - 32'd1;
			else if (sel == 2) v = '0;
			else if (sel < 7) v = $urandom_range(3000, 1);
			else if (sel < 9) v = $urandom_range(32'h00FF_FFFF, 0);
		end
		REG_ASPECT_MULT: begin
			if (sel < 3) v = '0;
			else if (sel == 3) v = 32'd1;
			else if (sel == 4) v = ALL_ONES_32;
			else if (sel < 7) v = $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
		end
		REG_BOX_X_LOW, REG_BOX_Y_LOW: begin
			if (sel < 3) v = S32_MIN;
			else if (sel < 7)
				v = ((idx == REG_BOX_X_LOW) ? plan_cx : plan_cy) - $urandom_range(4000, 0);
		end
		REG_BOX_X_HIGH, REG_BOX_Y_HIGH: begin
			if (sel < 3) v = S32_MAX;
			else if (sel < 7)
				v = ((idx == REG_BOX_X_HIGH) ? plan_cx : plan_cy) + $urandom_range(4000, 0);
		end
		default: ;
		endcase
		return v;
	endfunction

	// Mostly points around the planned circle, some on its rim, some extreme or anywhere
	function automatic point_t pick_point();
		point_t p;
		int unsigned sel;
		logic [31:0] span, mag;
		sel = $urandom_range(9, 0);
		span = (plan_r > 32'h4000_0000) ? ALL_ONES_32 : plan_r + (plan_r >> 2) + 32'd2;
		p.point_x = $urandom();
		p.point_y = $urandom();
		if (sel < 6) begin
			p.point_x = plan_cx + near_offset(span << $urandom_range(1, 0));
			p.point_y = plan_cy + near_offset(span);
		end else if (sel == 6) begin
			mag = plan_r + $urandom_range(1, 0);
			p.point_x = plan_cx + near_offset(span);
			p.point_y = ($urandom_range(1, 0) != 0) ? plan_cy + mag : plan_cy - mag;
		end else if (sel == 7) begin
			p.point_x = extreme_value();
			p.point_y = extreme_value();
		end
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Driver: walks the stimulus queue; all inputs but reset change here
	// ------------------------------------------------------------------
	result_t expected_results [$];
	result_t held_result;
	int unsigned send_idle_pct = 0, recv_idle_pct = 0;
	int unsigned quiet_cycles = 0;
	logic stim_done = 1'b0;

	always @(posedge clk) begin : drive_proc
		cmd_t nxt;
		logic pv_next, we_next;
		if (arst_n) begin
			pv_next = point_valid;
			we_next = 1'b0;

			// retire the point transaction that completed at this edge
			if (point_valid && !point_stall) begin
				expected_results.push_back(held_result);
				pv_next = 1'b0;
			end

			// count cycles with nothing in flight; gates writes and the end of run
			if (point_valid || expected_results.size() != 0)
				quiet_cycles = 0;
			else if (quiet_cycles < QUIET_CYCLES)
				quiet_cycles++;

			while (stim_q.size() != 0 && stim_q[0].kind == CMD_PACE) begin
				nxt = stim_q.pop_front();
				send_idle_pct = nxt.send_pct;
				recv_idle_pct = nxt.recv_pct;
			end

			if (!pv_next && stim_q.size() != 0) begin
				nxt = stim_q[0];
				if (nxt.kind == CMD_CFG) begin
					// write only once the pipeline has drained and settled
					if (quiet_cycles >= QUIET_CYCLES) begin
						we_next = 1'b1;
						cfg_index <= nxt.idx;
						cfg_wdata <= nxt.data;
						apply_cfg(nxt.idx, nxt.data);
						quiet_cycles = 0;
						nxt = stim_q.pop_front();
					end
				end else if ($urandom_range(99, 0) >= send_idle_pct) begin
					// present the next point; the query cannot change while it is in flight
					pv_next = 1'b1;
					point <= nxt.pt;
					held_result = nxt.has_exp ? nxt.exp_res : filter_point(nxt.pt);
					nxt = stim_q.pop_front();
				end
			end

			point_valid <= pv_next;
			cfg_we <= we_next;
			result_stall <= ($urandom_range(99, 0) < recv_idle_pct);
			stim_done = (stim_q.size() == 0) && !pv_next && (quiet_cycles >= QUIET_CYCLES);
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	int unsigned err_cnt = 0;
	int unsigned results_seen = 0;

	function automatic void note_failure(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endfunction

	always @(posedge clk) begin : check_proc
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				note_failure($sformatf("result %0d arrived with none pending: inside %0b dist %h",
					results_seen, result.inside_res, result.sq_distance));
			end else begin
				want = expected_results.pop_front();
				if (result.inside_res !== want.inside_res)
					note_failure($sformatf("result %0d inside_res: expected %0b, got %0b",
						results_seen, want.inside_res, result.inside_res));
				if (result.sq_distance !== want.sq_distance)
					note_failure($sformatf("result %0d sq_distance: expected %h, got %h",
						results_seen, want.sq_distance, result.sq_distance));
			end
		end
	end

	// Hard stop in case the handshake hangs
	int unsigned cycle_cnt = 0;

	always @(posedge clk) begin : watchdog_proc
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_proc
		cmd_t directed_tbl [$];
		logic [CFG_IDX_W-1:0] idx;
		int blk_items;
		int left;

		reset_query();

		// Directed table: typed expectations only where they are obvious
		directed_tbl = {
			pace_row(SEND_IDLE[0], RECV_IDLE[0]),
			// reset query: center at origin, unlimited radius, full box
			check_row(0, 0, 1'b1, 64'd0),
			check_row(S32_MIN, S32_MIN, 1'b1, 64'h8000_0000_0000_0000),
			check_row(S32_MAX, S32_MAX, 1'b1, 64'h7FFF_FFFE_0000_0002),
			// largest differences: sum of squares wraps
			cfg_row(REG_CENTER_X, S32_MIN),
			cfg_row(REG_CENTER_Y, S32_MIN),
			check_row(S32_MAX, S32_MAX, 1'b1, 64'hFFFF_FFFC_0000_0002),
			// zero radius: only the center itself is inside
			cfg_row(REG_CENTER_X, '0),
			cfg_row(REG_CENTER_Y, '0),
			cfg_row(REG_RADIUS, '0),
			check_row(0, 0, 1'b1, 64'd0),
			check_row(1, 0, 1'b0, 64'd1),
			// radius 100: on the circle, just past it, box edge
			cfg_row(REG_RADIUS, 32'd100),
			check_row(60, 80, 1'b1, 64'd10000),
			check_row(61, 80, 1'b0, 64'd10121),
			check_row(0, -101, 1'b0, 64'd10201),
			check_row(100, 0, 1'b1, 64'd10000),
			// aspect one half: x half-width grows to 201
			cfg_row(REG_ASPECT_MULT, 32'h8000_0000),
			check_row(200, 0, 1'b1, 64'd10000),
			check_row(-202, 0, 1'b0, 64'd10201),
			// aspect near one
			cfg_row(REG_ASPECT_MULT, ALL_ONES_32),
			point_row(S32_MIN, 0),
			point_row(101, 0),
			// tiny aspect: half-width saturates, x difference scales to zero
			cfg_row(REG_ASPECT_MULT, 32'd1),
			cfg_row(REG_RADIUS, 32'd5),
			check_row(S32_MAX, 0, 1'b1, 64'd0),
			// inverted x box: nothing is inside, distance still reported
			cfg_row(REG_BOX_X_LOW, 32'd10),
			cfg_row(REG_BOX_X_HIGH, 32'd5),
			check_row(7, 0, 1'b0, 64'd0),
			// unlimited radius with a narrow user y box
			cfg_row(REG_RADIUS, ALL_ONES_32),
			cfg_row(REG_ASPECT_MULT, '0),
			cfg_row(REG_BOX_X_LOW, S32_MIN),
			cfg_row(REG_BOX_X_HIGH, S32_MAX),
			cfg_row(REG_BOX_Y_LOW, -32'sd3),
			cfg_row(REG_BOX_Y_HIGH, 32'sd3),
			check_row(0, 3, 1'b1, 64'd9),
			check_row(0, 4, 1'b0, 64'd16),
			check_row(0, -4, 1'b0, 64'd16),
			// writes past the register file change nothing
			cfg_row(REG_UNUSED_FIRST, 32'd1000),
			cfg_row(REG_UNUSED_LAST, 32'd7),
			check_row(0, 4, 1'b0, 64'd16),
			// largest finite radius
			cfg_row(REG_BOX_Y_LOW, S32_MIN),
			cfg_row(REG_BOX_Y_HIGH, S32_MAX),
			cfg_row(REG_RADIUS, ALL_ONES_32 - 32'd1),
			point_row(S32_MIN, S32_MAX),
			point_row(S32_MAX, S32_MIN)
		};
		foreach (directed_tbl[i])
			queue_cmd(directed_tbl[i]);

		// Random part: per phase, blocks of points behind a few register writes
		for (int ph = 0; ph < 3; ph++) begin
			queue_cmd(pace_row(SEND_IDLE[ph], RECV_IDLE[ph]));
			left = RANDOM_PER_PHASE;
			while (left > 0) begin
				// reopen the user box now and then so inside hits stay common
				if ($urandom_range(3, 0) == 0) begin
					queue_cmd(cfg_row(REG_BOX_X_LOW, S32_MIN));
					queue_cmd(cfg_row(REG_BOX_X_HIGH, S32_MAX));
					queue_cmd(cfg_row(REG_BOX_Y_LOW, S32_MIN));
					queue_cmd(cfg_row(REG_BOX_Y_HIGH, S32_MAX));
				end
				repeat ($urandom_range(3, 1)) begin
					if ($urandom_range(19, 0) == 0)
						idx = CFG_IDX_W'($urandom_range(255, CFG_REGS));
					else
						idx = CFG_IDX_W'($urandom_range(CFG_REGS - 1, 0));
					queue_cmd(cfg_row(idx, pick_cfg_value(idx)));
				end
				blk_items = $urandom_range(40, 8);
				repeat (blk_items) begin
					point_t p;
					p = pick_point();
					queue_cmd(point_row(p.point_x, p.point_y));
				end
				left -= blk_items;
			end
		end

		// Hold reset, then release it on a rising edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Run until the stream is spent and the pipeline has been quiet a while
		do
			@(posedge clk);
		while (!stim_done);

		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/geo_prb_pkg.sv
rtl/core/geo_prb_div.sv
rtl/core/geo_prb_cfg.sv
rtl/core/geo_prb_pipe.sv
rtl/core/geo_point_radius_box_filter_core.sv
verif/tb_top.sv
